// ===== hw/rtl/vaf_pkg.sv =====
// Shared types and constants of the van Albada flux limiter.
// Fixed-point widths, pipeline word structs and result limits.
// No dependencies.
`default_nettype none

package vaf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int MAG_W     = IN_W;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int PHI_W     = FRAC_BITS + 1;
    localparam int BAND_W    = 16;
    localparam int STEP_N    = FRAC_BITS;
    localparam logic [PHI_W-1:0] ONE_FIX = PHI_W'(1) << FRAC_BITS;
    localparam logic [PHI_W-1:0] PHI_MAX = PHI_W'(79110);

    typedef struct packed {
        logic [MAG_W-1:0] na;
        logic [MAG_W-1:0] da;
        logic             force_en;
        logic             force_one;
    } prep_word_t;

    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [PROD_W-1:0] den;
        logic [PHI_W-1:0]  quo;
        logic              force_en;
        logic              force_one;
    } div_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vaf_prep.sv =====
// Input stage: sign split, magnitudes, opposite-sign and zero-band checks.
// Depends on vaf_pkg.
`default_nettype none

module vaf_prep (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire logic [vaf_pkg::IN_W-1:0]  numerator,
    input  wire logic [vaf_pkg::IN_W-1:0]  denominator,
    input  wire logic [vaf_pkg::BAND_W-1:0] band,
    output logic                           out_valid,
    output vaf_pkg::prep_word_t            out_word
);
    import vaf_pkg::*;

    logic       valid_reg;
    prep_word_t word_reg;
    prep_word_t word_next;
    logic       nneg;
    logic       dneg;
    logic       nzero;
    logic       dzero;
    logic       opp;

    always_comb
    begin
        nneg  = numerator[IN_W-1];
        dneg  = denominator[IN_W-1];
        word_next.na = nneg ? (~numerator + MAG_W'(1)) : numerator;
        word_next.da = dneg ? (~denominator + MAG_W'(1)) : denominator;
        nzero = (numerator == '0);
        dzero = (denominator == '0);
        opp   = !nzero && !dzero && (nneg != dneg);
        word_next.force_one = !opp && ((word_next.da < MAG_W'(band)) || (nzero && dzero));
        word_next.force_en  = opp || word_next.force_one;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/vaf_arith.sv =====
// Three stages: squares and cross product, numerator and denominator sums,
// integer quotient bit. Depends on vaf_pkg.
`default_nettype none

module vaf_arith (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire vaf_pkg::prep_word_t in_word,
    output logic               out_valid,
    output vaf_pkg::div_word_t  out_word
);
    import vaf_pkg::*;

    logic [2:0]        valid_reg;
    logic [PROD_W-1:0] nn_reg;
    logic [PROD_W-1:0] nd_reg;
    logic [PROD_W-1:0] dd_reg;
    logic              fen1_reg;
    logic              fone1_reg;
    logic [PROD_W-1:0] num_reg;
    logic [PROD_W-1:0] den_reg;
    logic              fen2_reg;
    logic              fone2_reg;
    div_word_t         word_reg;
    div_word_t         word_next;
    logic              ge;

    always_comb
    begin
        ge = (num_reg >= den_reg);
        word_next.rem       = ge ? (num_reg - den_reg) : num_reg;
        word_next.den       = den_reg;
        word_next.quo       = {{(PHI_W-1){1'b0}}, ge};
        word_next.force_en  = fen2_reg;
        word_next.force_one = fone2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nn_reg    <= PROD_W'(in_word.na) * PROD_W'(in_word.na);
            nd_reg    <= PROD_W'(in_word.na) * PROD_W'(in_word.da);
            dd_reg    <= PROD_W'(in_word.da) * PROD_W'(in_word.da);
            fen1_reg  <= in_word.force_en;
            fone1_reg <= in_word.force_one;
            num_reg   <= nn_reg + nd_reg;
            den_reg   <= nn_reg + dd_reg;
            fen2_reg  <= fen1_reg;
            fone2_reg <= fone1_reg;
            word_reg  <= word_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/vaf_div_step.sv =====
// One restoring division stage: shift remainder, trial subtract, one quotient bit.
// Depends on vaf_pkg.
`default_nettype none

module vaf_div_step (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         adv,
    input  wire logic         in_valid,
    input  wire vaf_pkg::div_word_t in_word,
    output logic              out_valid,
    output vaf_pkg::div_word_t out_word
);
    import vaf_pkg::*;

    logic             valid_reg;
    div_word_t        word_reg;
    div_word_t        word_next;
    logic [PROD_W:0]  shifted;
    logic [PROD_W:0]  diff;
    logic             ge;

    always_comb
    begin
        shifted = {in_word.rem, 1'b0};
        diff    = shifted - {1'b0, in_word.den};
        ge      = !diff[PROD_W];
        word_next.rem       = ge ? diff[PROD_W-1:0] : shifted[PROD_W-1:0];
        word_next.den       = in_word.den;
        word_next.quo       = {in_word.quo[PHI_W-2:0], ge};
        word_next.force_en  = in_word.force_en;
        word_next.force_one = in_word.force_one;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/van_albada_flux_limiter.sv =====
// Top level of the van Albada flux limiter: zero-band register, pipeline, output skid.
// Depends on vaf_pkg, vaf_prep, vaf_arith, vaf_div_step.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    numerator[31:0], denominator[31:0]
//   out      out_valid / out_stall  phi[16:0]
//   cfg      cfg_valid / cfg_ready  zero_band[15:0]
//
// One word enters per cycle while in_stall is low.
// The pipeline is 1 prep stage, 3 multiply/sum/integer-bit stages,
// 16 division stages and the output register.
// A stalled result parks in a one-word skid; in_stall is the skid-full flag, registered.
// Reset clears all valid bits and loads the zero-band register with 1; cfg_ready is always high.
`default_nettype none

module van_albada_flux_limiter (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [vaf_pkg::IN_W-1:0]   numerator,
    input  wire logic [vaf_pkg::IN_W-1:0]   denominator,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [vaf_pkg::PHI_W-1:0]       phi,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [vaf_pkg::BAND_W-1:0] zero_band
);
    import vaf_pkg::*;

    logic [BAND_W-1:0] band_reg;
    logic              adv;
    logic              prep_valid;
    prep_word_t        prep_word;
    logic [STEP_N:0]   stage_valid;
    div_word_t         stage_word [STEP_N+1];
    logic [PHI_W-1:0]  pipe_phi;
    logic              pipe_valid;
    logic              out_ready;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [PHI_W-1:0]  out_phi_reg;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [PHI_W-1:0]  skid_phi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            band_reg <= BAND_W'(1);
        else if (cfg_valid && cfg_ready)
            band_reg <= zero_band;
    end

    // advance the whole pipeline while the skid is empty
    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    vaf_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (in_valid),
        .numerator   (numerator),
        .denominator (denominator),
        .band        (band_reg),
        .out_valid   (prep_valid),
        .out_word    (prep_word)
    );

    vaf_arith u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (prep_valid),
        .in_word   (prep_word),
        .out_valid (stage_valid[0]),
        .out_word  (stage_word[0])
    );

    for (genvar i = 0; i < STEP_N; i++)
    begin : g_step
        vaf_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (stage_valid[i]),
            .in_word   (stage_word[i]),
            .out_valid (stage_valid[i+1]),
            .out_word  (stage_word[i+1])
        );
    end

    assign pipe_valid = stage_valid[STEP_N];
    assign pipe_phi   = stage_word[STEP_N].force_en
                      ? (stage_word[STEP_N].force_one ? ONE_FIX : '0)
                      : stage_word[STEP_N].quo;

    assign out_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_ready)
        begin
            out_valid_next  = skid_valid_reg || pipe_valid;
            skid_valid_next = 1'b0;
        end
        else if (pipe_valid && adv)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
            out_phi_reg <= skid_valid_reg ? skid_phi_reg : pipe_phi;
        else if (pipe_valid && adv)
            skid_phi_reg <= pipe_phi;
    end

    assign out_valid = out_valid_reg;
    assign phi       = out_phi_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/vaf_checker.sv =====
// Port-level checks for the van Albada flux limiter, bound to the top level.
// Depends on vaf_pkg and van_albada_flux_limiter.
`default_nettype none

module vaf_checker (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_stall,
    input wire logic                     out_valid,
    input wire logic                     out_stall,
    input wire logic [vaf_pkg::PHI_W-1:0] phi
);
    import vaf_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(phi))
        else $error("stalled result word changed or dropped");

    a_phi_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> phi <= PHI_MAX)
        else $error("phi above limiter bound");

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result word waiting");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without a stalled output");

endmodule

bind van_albada_flux_limiter vaf_checker u_vaf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .phi       (phi)
);

`default_nettype wire
